// ===== sv/gwwa_pkg.sv =====
// Shared types and constants for the geometric weighted window average.
// Used by the history cells, the divider and the top level.
package gwwa_pkg;

	localparam int unsigned HistDepth = 16;
	localparam int unsigned SlotW     = $clog2(HistDepth);
	localparam int unsigned FillW     = $clog2(HistDepth + 1);
	localparam int unsigned PosW      = 24;
	localparam int unsigned WgtW      = 17;
	localparam int unsigned ProdW     = PosW + WgtW + 1;
	localparam int unsigned WsumW     = WgtW + SlotW;
	localparam int unsigned SumW      = ProdW + SlotW - 1;
	localparam int unsigned MagW      = SumW - 1;
	localparam logic [WgtW-1:0] OneQ16 = WgtW'(65536);

	localparam logic [1:0] RegHistorySize   = 2'd0;
	localparam logic [1:0] RegAverageFactor = 2'd1;
	localparam logic [1:0] RegJointWeight   = 2'd2;

	localparam logic CmdSample = 1'b0;
	localparam logic CmdClear  = 1'b1;

	typedef struct packed {
		logic signed [PosW-1:0] x;
		logic signed [PosW-1:0] y;
		logic signed [PosW-1:0] z;
	} pos_t;

	typedef struct packed {
		logic push;
		logic rot;
	} cell_ctrl_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ACC  = 5'b00010,
		S_SUM  = 5'b00100,
		S_DIV  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

endpackage

// ===== sv/gwwa_cell.sv =====
// One history cell: holds one x,y,z sample of the window.
// Depends on gwwa_pkg; shifts in on a push, rotates towards the head on a walk.
module gwwa_cell import gwwa_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  pos_t       shift_in,
	input  pos_t       rot_in,
	output pos_t       pos
);

	pos_t pos_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			pos_q <= shift_in;
		end else if (ctrl.rot) begin
			pos_q <= rot_in;
		end
	end

	assign pos = pos_q;

endmodule

// ===== sv/gwwa_div.sv =====
// Restoring divider for one axis, one quotient bit a cycle, signed and saturated.
// Depends on gwwa_pkg; the quotient magnitude never exceeds 2^23.
module gwwa_div import gwwa_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SumW-1:0]  num,
	input  logic        [WsumW-1:0] den,
	output logic                    done,
	output logic signed [PosW-1:0]  quot
);

	localparam int unsigned CntW = $clog2(PosW);

	logic [MagW-1:0] rem_q;
	logic [MagW-1:0] dvs_q;
	logic [PosW-1:0] mag_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            neg_q;
	logic            done_q;
	logic signed [PosW-1:0] quot_q;
	logic [SumW-1:0] num_abs;
	logic            fits;

	assign num_abs = num[SumW-1] ? SumW'(-num) : SumW'(num);
	assign fits    = rem_q >= dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CntW'(PosW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[SumW-1];
			rem_q <= num_abs[MagW-1:0];
			dvs_q <= MagW'(den) << (PosW - 1);
			mag_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dvs_q;
			end
			mag_q <= {mag_q[PosW-2:0], fits};
			dvs_q <= dvs_q >> 1;
			if (cnt_q == CntW'(PosW - 1)) begin
				if (neg_q) begin
					quot_q <= PosW'(-{mag_q[PosW-2:0], fits});
				end else if (mag_q[PosW-2]) begin
					// magnitude reached 2^23: clamp to the largest positive value
					quot_q <= {1'b0, {(PosW-1){1'b1}}};
				end else begin
					quot_q <= {mag_q[PosW-2:0], fits};
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== sv/geometric_weighted_window_average.sv =====
// Top level of the geometric weighted window average: history cell row,
// weighted accumulation and three dividers. Depends on gwwa_pkg, gwwa_cell, gwwa_div.
//
//  channel | signals                                          | direction
//  in      | in_valid, in_stall, command, pos_x/y/z, joint_kind, track_state | sink
//  out     | out_valid, out_stall, avg_x/y/z, out_joint_kind, out_track_state | source
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data        | sink
//
// A sample beat passes through the walk round the cell ring, the settling of the sums,
// the bit-serial divide, and then loading and output.
// A clear beat empties the window and gives no result.
// in_stall is high from an accepted sample until its result sits in the output register.
// A stalled result holds in the output register; the next beat is still taken.
// Reset empties the window and loads the register defaults.
module geometric_weighted_window_average import gwwa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   command,
	input  logic signed [PosW-1:0] pos_x,
	input  logic signed [PosW-1:0] pos_y,
	input  logic signed [PosW-1:0] pos_z,
	input  logic [4:0]             joint_kind,
	input  logic [1:0]             track_state,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [PosW-1:0] avg_x,
	output logic signed [PosW-1:0] avg_y,
	output logic signed [PosW-1:0] avg_z,
	output logic [4:0]             out_joint_kind,
	output logic [1:0]             out_track_state,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [WgtW-1:0]        cfg_data
);

	state_t state_q;

	logic [FillW-1:0] size_q;
	logic [WgtW-1:0]  factor_q;
	logic [WgtW-1:0]  jweight_q;
	logic [FillW-1:0] fill_q;
	logic [SlotW-1:0] step_q;
	logic [WgtW-1:0]  decay_q;
	logic [WgtW-1:0]  w_q;
	logic [4:0]       kind_q;
	logic [1:0]       track_q;
	logic             div_start_q;

	logic signed [ProdW-1:0] px_s1, py_s1, pz_s1;
	logic [WgtW-1:0]         pw_s1;
	logic signed [SumW-1:0]  sx_q, sy_q, sz_q;
	logic [WsumW-1:0]        wsum_q;

	logic out_valid_q;
	logic signed [PosW-1:0] ax_q, ay_q, az_q;
	logic [4:0] okind_q;
	logic [1:0] otrack_q;

	logic in_acc, sample_acc, clear_acc, in_window, out_free, div_start;
	logic done_x, done_y, done_z;
	logic signed [PosW-1:0] qx, qy, qz;
	logic [FillW-1:0] size_eff, fill_next;
	logic [WgtW-1:0]  fa_eff, fj_eff;
	logic [2*WgtW-1:0] decay_full, w_full;
	logic [WgtW-1:0]  win_w;
	pos_t win_pos;
	cell_ctrl_t ctrl;
	pos_t new_pos;
	pos_t cell_pos [HistDepth];

	assign in_stall   = state_q != S_IDLE;
	assign in_acc     = in_valid && !in_stall;
	assign sample_acc = in_acc && command == CmdSample;
	assign clear_acc  = in_acc && command == CmdClear;
	assign cfg_ready  = 1'b1;
	assign out_free   = !out_valid_q || !out_stall;
	assign div_start  = div_start_q;

	always_comb begin
		if (size_q == '0) begin
			size_eff = FillW'(1);
		end else if (size_q > FillW'(HistDepth)) begin
			size_eff = FillW'(HistDepth);
		end else begin
			size_eff = size_q;
		end
	end

	assign fill_next  = (fill_q >= size_eff) ? size_eff : fill_q + 1'b1;
	assign fa_eff     = (factor_q > OneQ16) ? OneQ16 : factor_q;
	assign fj_eff     = (jweight_q > OneQ16) ? OneQ16 : jweight_q;
	assign decay_full = fa_eff * fj_eff;
	assign w_full     = w_q * decay_q;
	assign in_window  = {1'b0, step_q} < fill_q;
	// drop entries beyond the window: zero both the weight and the position
	assign win_w      = in_window ? w_q : '0;
	assign win_pos    = in_window ? cell_pos[0] : '0;

	assign ctrl.push = sample_acc;
	assign ctrl.rot  = state_q == S_ACC;
	assign new_pos   = '{x: pos_x, y: pos_y, z: pos_z};

	for (genvar i = 0; i < HistDepth; i++) begin : g_cell
		gwwa_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.shift_in ((i == 0) ? new_pos : cell_pos[(i + HistDepth - 1) % HistDepth]),
			.rot_in   (cell_pos[(i + 1) % HistDepth]),
			.pos      (cell_pos[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			size_q      <= FillW'(4);
			factor_q    <= WgtW'(32768);
			jweight_q   <= OneQ16;
			fill_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					RegHistorySize:   size_q    <= cfg_data[FillW-1:0];
					RegAverageFactor: factor_q  <= cfg_data;
					RegJointWeight:   jweight_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// start the divide once the last product has landed in the sums
			div_start_q <= state_q == S_SUM;
			unique case (state_q)
				S_IDLE: begin
					if (clear_acc) begin
						fill_q <= '0;
					end else if (sample_acc) begin
						fill_q  <= fill_next;
						step_q  <= '0;
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					step_q <= step_q + 1'b1;
					if (step_q == SlotW'(HistDepth - 1)) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: state_q <= S_DIV;
				S_DIV: begin
					if (done_x && done_y && done_z) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc) begin
			kind_q  <= joint_kind;
			track_q <= track_state;
			decay_q <= decay_full[2*WgtW-2:WgtW-1];
			w_q     <= OneQ16;
			sx_q    <= '0;
			sy_q    <= '0;
			sz_q    <= '0;
			wsum_q  <= '0;
		end else begin
			if (state_q == S_ACC) begin
				w_q <= w_full[2*WgtW-2:WgtW-1];
			end
			// the product stage is registered behind the walk; add each product in the cycle after its step
			if (state_q == S_ACC || state_q == S_SUM) begin
				if (step_q != '0 || state_q == S_SUM) begin
					sx_q   <= sx_q + SumW'(px_s1);
					sy_q   <= sy_q + SumW'(py_s1);
					sz_q   <= sz_q + SumW'(pz_s1);
					wsum_q <= wsum_q + WsumW'(pw_s1);
				end
			end
		end
		pw_s1 <= win_w;
		px_s1 <= win_pos.x * $signed({1'b0, win_w});
		py_s1 <= win_pos.y * $signed({1'b0, win_w});
		pz_s1 <= win_pos.z * $signed({1'b0, win_w});
		if (state_q == S_OUT && out_free) begin
			ax_q     <= qx;
			ay_q     <= qy;
			az_q     <= qz;
			okind_q  <= kind_q;
			otrack_q <= track_q;
		end
	end

	gwwa_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(sx_q), .den(wsum_q),
		.done(done_x), .quot(qx)
	);
	gwwa_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(sy_q), .den(wsum_q),
		.done(done_y), .quot(qy)
	);
	gwwa_div u_div_z (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(sz_q), .den(wsum_q),
		.done(done_z), .quot(qz)
	);

	assign out_valid       = out_valid_q;
	assign avg_x           = ax_q;
	assign avg_y           = ay_q;
	assign avg_z           = az_q;
	assign out_joint_kind  = okind_q;
	assign out_track_state = otrack_q;

endmodule

// ===== sv/gwwa_checker.sv =====
// Port-level checks for the geometric weighted window average.
// Depends on gwwa_pkg; bound to the top level at the end of this file.
module gwwa_checker import gwwa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic command,
	input logic out_valid,
	input logic out_stall,
	input logic cfg_ready
);

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command == CmdSample |=> in_stall)
		else $error("sample beat did not make the block busy");

	a_clear_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command == CmdClear |=> !in_stall)
		else $error("clear beat left the block busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

endmodule

bind geometric_weighted_window_average gwwa_checker u_gwwa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.command(command), .out_valid(out_valid), .out_stall(out_stall),
	.cfg_ready(cfg_ready)
);
